[hw/rtl/clc_pkg.sv]
// ---------------------------------------------------------------------------
// clc_pkg: shared types and constants of the collective lift controller
// Holds the item, filter, configuration and result structs, mode codes and
// register indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package clc_pkg;

	localparam logic [3:0] NO_KEY = 4'd15;

	// configuration register indexes
	localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [2:0] REG_RUN_TMO    = 3'd1;
	localparam logic [2:0] REG_DOOR_MOVE  = 3'd2;
	localparam logic [2:0] REG_DOOR_HOLD  = 3'd3;
	localparam logic [2:0] REG_STOP_LOCK  = 3'd4;
	localparam logic [2:0] REG_CLOSE_TRY  = 3'd5;
	localparam logic [2:0] REG_OPEN_KEY   = 3'd6;
	localparam logic [2:0] REG_CLOSE_KEY  = 3'd7;

	// display status ids (high nibble)
	localparam logic [3:0] ST_FLOOR   = 4'd0;
	localparam logic [3:0] ST_UP      = 4'd1;
	localparam logic [3:0] ST_DOWN    = 4'd2;
	localparam logic [3:0] ST_BETWEEN = 4'd3;
	localparam logic [3:0] ST_UNKNOWN = 4'd4;
	localparam logic [3:0] ST_SWITCH  = 4'd5;
	localparam logic [3:0] ST_TIMEOUT = 4'd6;
	localparam logic [3:0] ST_CHAIN   = 4'd7;
	localparam logic [3:0] ST_HOMING  = 4'd8;
	localparam logic [3:0] ST_COUNT   = 4'd9;
	localparam logic [3:0] ST_OPENING = 4'd10;
	localparam logic [3:0] ST_OPEN    = 4'd11;
	localparam logic [3:0] ST_CLOSING = 4'd12;
	localparam logic [3:0] ST_DOORFLT = 4'd13;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} run_mode_t;

	typedef enum logic [1:0] {
		DOOR_CLOSED  = 2'd0,
		DOOR_OPENING = 2'd1,
		DOOR_OPEN    = 2'd2,
		DOOR_CLOSING = 2'd3
	} door_mode_t;

	typedef struct packed {
		logic       door_closed_limit;
		logic       door_open_limit;
		logic       slow_down_vane;
		logic       slow_up_vane;
		logic       floor_vane;
		logic       bottom_limit;
		logic       landing_chain_open;
		logic [3:0] key_code;
		logic       hall_down_pressed;
		logic       hall_up_pressed;
	} item_t;

	typedef struct packed {
		logic       up_press;
		logic       down_press;
		logic       key_hit;
		logic [3:0] key;
		logic       chain;
		logic       bottom;
		logic       flr;
		logic       rise;
		logic       fall;
		logic       sup;
		logic       sdn;
		logic       dopen;
		logic       dclosed;
	} filt_t;

	typedef struct packed {
		logic [7:0]  debounce_count;
		logic [15:0] run_timeout_ticks;
		logic [15:0] door_move_ticks;
		logic [15:0] door_hold_ticks;
		logic [7:0]  stop_lock_ticks;
		logic [3:0]  close_tries_max;
		logic [3:0]  open_key_code;
		logic [3:0]  close_key_code;
	} cfg_t;

	typedef struct packed {
		logic        arrived;
		logic [3:0]  fault_flags;
		logic [7:0]  status_code;
		logic [15:0] call_mask;
		logic [3:0]  goal_floor;
		logic [3:0]  car_floor;
		logic        door_close_drive;
		logic        door_open_drive;
		logic        drive_fast;
		logic        drive_down;
		logic        drive_up;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/collective_lift_controller_top.sv]
// ---------------------------------------------------------------------------
// collective_lift_controller_top: two-speed collective lift controller
// Input register, filters and control, and an output register per tick.
// ---------------------------------------------------------------------------
// Each input transaction is one scan tick of raw inputs; each yields exactly
// one result transaction via the input and output registers. A tick can be
// accepted every cycle: the tick sits in an input register, the filters and
// control logic update all state in the cycle it moves into the output
// register, and the input side keeps accepting while a result waits as long
// as the output register can be emptied. Configuration writes take effect at
// once and are always accepted; write them only while no tick is in flight.
`default_nettype none
module collective_lift_controller_top #(
	parameter int FLOOR_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// hall_up_pressed, hall_down_pressed, key_code[3:0], landing_chain_open,
	// bottom_limit, floor_vane, slow_up_vane, slow_down_vane, door_open_limit,
	// door_closed_limit, 3 zero bits
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// drive_up, drive_down, drive_fast, door_open_drive, door_close_drive,
	// car_floor[3:0], goal_floor[3:0], call_mask[15:0], status_code[7:0],
	// fault_flags[3:0], arrived, 6 zero bits
	output logic [47:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import clc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    stall, adv;
	filt_t   filt;
	cfg_t    cfg_q;
	result_t res, res_q;

	assign stall     = m_tvalid && !m_tready;
	assign adv       = valid_s1 && !stall;
	assign s_tready  = !valid_s1 || !stall;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {6'd0, res_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= s_tdata[12:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count    <= 8'd5;
			cfg_q.run_timeout_ticks <= 16'd3000;
			cfg_q.door_move_ticks   <= 16'd80;
			cfg_q.door_hold_ticks   <= 16'd50;
			cfg_q.stop_lock_ticks   <= 8'd100;
			cfg_q.close_tries_max   <= 4'd3;
			cfg_q.open_key_code     <= 4'd9;
			cfg_q.close_key_code    <= 4'd11;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_count    <= cfg_data[7:0];
				REG_RUN_TMO:   cfg_q.run_timeout_ticks <= cfg_data;
				REG_DOOR_MOVE: cfg_q.door_move_ticks   <= cfg_data;
				REG_DOOR_HOLD: cfg_q.door_hold_ticks   <= cfg_data;
				REG_STOP_LOCK: cfg_q.stop_lock_ticks   <= cfg_data[7:0];
				REG_CLOSE_TRY: cfg_q.close_tries_max   <= cfg_data[3:0];
				REG_OPEN_KEY:  cfg_q.open_key_code     <= cfg_data[3:0];
				REG_CLOSE_KEY: cfg_q.close_key_code    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	clc_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.item           (item_s1),
		.debounce_count (cfg_q.debounce_count),
		.filt           (filt)
	);

	clc_ctrl #(
		.FLOOR_COUNT (FLOOR_COUNT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.filt   (filt),
		.cfg    (cfg_q),
		.res    (res)
	);

`ifndef SYNTHESIS
	// never drive both directions
	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.drive_up && res_q.drive_down))
		else $error("both direction relays on");

	// door motor stays off while the car moves
	a_door_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.drive_up || res_q.drive_down)
			|-> !(res_q.door_open_drive || res_q.door_close_drive))
		else $error("door driven while running");

	// fast speed only during a run
	a_fast_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.drive_fast |-> (res_q.drive_up || res_q.drive_down))
		else $error("fast relay without direction");
`endif

endmodule
`default_nettype wire

[hw/rtl/clc_debounce.sv]
// ---------------------------------------------------------------------------
// clc_debounce: input filters
// Pulse, level and hysteresis filters on the raw inputs, keypad repeat
// detection and floor vane edge detection, advanced once per tick.
// ---------------------------------------------------------------------------
`default_nettype none
module clc_debounce (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire clc_pkg::item_t item,
	input  wire logic [7:0]     debounce_count,
	output clc_pkg::filt_t      filt
);
	import clc_pkg::*;

	logic [7:0] cnt_q [10];
	logic [7:0] cnt_d [10];
	logic [3:0] prev_key_q;
	logic       bottom_q, flr_q;
	logic       bottom_d, flr_d;
	logic [7:0] deb;
	logic [9:0] raw;

	assign deb = (debounce_count == 8'd0) ? 8'd1 : debounce_count;
	assign raw = {item.door_closed_limit, item.door_open_limit, item.slow_down_vane,
		item.slow_up_vane, item.floor_vane, item.bottom_limit,
		item.landing_chain_open, 1'b0, item.hall_down_pressed, item.hall_up_pressed};

	// next filter counts and filtered outputs
	always_comb begin
		for (int i = 0; i < 10; i++) begin
			cnt_d[i] = cnt_q[i];
		end
		// pulse filters: saturate at 255, fire on reaching the threshold
		for (int i = 0; i < 10; i++) begin
			if (i == 0 || i == 1 || i == 6 || i == 7) begin
				if (raw[i]) cnt_d[i] = (cnt_q[i] < 8'd255) ? cnt_q[i] + 8'd1 : cnt_q[i];
				else cnt_d[i] = 8'd0;
			end
		end
		// keypad: count repeats of the same code
		if (item.key_code != NO_KEY && item.key_code == prev_key_q)
			cnt_d[2] = (cnt_q[2] < 8'd255) ? cnt_q[2] + 8'd1 : cnt_q[2];
		else
			cnt_d[2] = 8'd0;
		// level filters
		for (int i = 0; i < 10; i++) begin
			if (i == 3 || i == 8 || i == 9) begin
				if (raw[i]) cnt_d[i] = (cnt_q[i] < deb) ? cnt_q[i] + 8'd1 : cnt_q[i];
				else cnt_d[i] = 8'd0;
			end
		end
		// hysteresis filters
		for (int i = 4; i < 6; i++) begin
			if (raw[i]) cnt_d[i] = (cnt_q[i] < deb) ? cnt_q[i] + 8'd1 : cnt_q[i];
			else if (cnt_q[i] != 8'd0) cnt_d[i] = cnt_q[i] - 8'd1;
		end
		if (cnt_d[4] >= deb) bottom_d = 1'b1;
		else if (cnt_d[4] == 8'd0) bottom_d = 1'b0;
		else bottom_d = bottom_q;
		if (cnt_d[5] >= deb) flr_d = 1'b1;
		else if (cnt_d[5] == 8'd0) flr_d = 1'b0;
		else flr_d = flr_q;

		filt.up_press   = cnt_d[0] == deb;
		filt.down_press = cnt_d[1] == deb;
		filt.key_hit    = cnt_d[2] == deb;
		filt.key        = item.key_code;
		filt.chain      = cnt_d[3] >= deb;
		filt.bottom     = bottom_d;
		filt.flr        = flr_d;
		filt.rise       = flr_d && !flr_q;
		filt.fall       = !flr_d && flr_q;
		filt.sup        = cnt_d[6] == deb;
		filt.sdn        = cnt_d[7] == deb;
		filt.dopen      = cnt_d[8] >= deb;
		filt.dclosed    = cnt_d[9] >= deb;
	end

	// advance filter state on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 10; i++) cnt_q[i] <= 8'd0;
			prev_key_q <= NO_KEY;
			bottom_q   <= 1'b0;
			flr_q      <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < 10; i++) cnt_q[i] <= cnt_d[i];
			prev_key_q <= item.key_code;
			bottom_q   <= bottom_d;
			flr_q      <= flr_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/clc_ctrl.sv]
// ---------------------------------------------------------------------------
// clc_ctrl: car motion, call queue and door control
// Collective call selection, run supervision, homing, fault flags and the
// automatic door state machine, advanced once per tick.
// ---------------------------------------------------------------------------
`default_nettype none
module clc_ctrl #(
	parameter int FLOOR_COUNT = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire clc_pkg::filt_t filt,
	input  wire clc_pkg::cfg_t  cfg,
	output clc_pkg::result_t    res
);
	import clc_pkg::*;

	localparam logic [4:0] TOP = 5'(FLOOR_COUNT - 1);
	localparam logic [4:0] FC  = 5'(FLOOR_COUNT);

	typedef struct packed {
		logic       ok;
		logic [3:0] hit;
	} find_t;

	run_mode_t   mode_q, mode_d;
	door_mode_t  door_q, door_d;
	logic [3:0]  fnow_q, fnow_d, goal_q, goal_d;
	logic [15:0] calls_q, calls_d;
	logic        mid_q, known_q, homing_q, homereq_q, lastup_q, passed_q, fast_q;
	logic        mid, known, homing, homereq, lastup, passed, fast;
	logic [15:0] dtmr_q, dtmr_d, rtmr_q, rtmr_d;
	logic [3:0]  cfail_q, cfail_d;
	logic [7:0]  lock_q, lock_d;
	logic        fcnt_q, ftime_q, fdoor_q;
	logic        fcnt, ftime, fdoor;

	// lowest call at or above a floor
	function automatic find_t find_up(logic [15:0] m, logic [4:0] from);
		find_t r;
		r = '0;
		for (int f = 15; f >= 0; f--) begin
			if (5'(f) >= from && 5'(f) < FC && m[f]) begin
				r.ok  = 1'b1;
				r.hit = 4'(f);
			end
		end
		return r;
	endfunction

	// highest call at or below a floor
	function automatic find_t find_down(logic [15:0] m, logic [4:0] from);
		find_t r;
		r = '0;
		for (int f = 0; f < 16; f++) begin
			if (5'(f) <= from && from < FC && m[f]) begin
				r.ok  = 1'b1;
				r.hit = 4'(f);
			end
		end
		return r;
	endfunction

	// one tick of motion and door control
	always_comb begin
		logic       sw_fault, reached, arr, open_key, close_key, open_drv, close_drv;
		logic       door_ok, go, go_up;
		logic [4:0] idx;
		logic [3:0] pick;
		logic [7:0] status;
		find_t      fu, fd, f2;

		mode_d = mode_q; door_d = door_q; fnow_d = fnow_q; goal_d = goal_q;
		calls_d = calls_q; dtmr_d = dtmr_q; rtmr_d = rtmr_q; cfail_d = cfail_q;
		lock_d = lock_q;
		mid = mid_q; known = known_q; homing = homing_q; homereq = homereq_q;
		lastup = lastup_q; passed = passed_q; fast = fast_q;
		fcnt = fcnt_q; ftime = ftime_q; fdoor = fdoor_q;
		reached = 1'b0; arr = 1'b0; open_drv = 1'b0; close_drv = 1'b0;
		go = 1'b0; go_up = 1'b0; pick = 4'd0; idx = 5'd0; door_ok = 1'b0;
		fu = '0; fd = '0; f2 = '0;
		sw_fault  = filt.bottom && filt.flr;
		open_key  = filt.key_hit && filt.key == cfg.open_key_code;
		close_key = filt.key_hit && filt.key == cfg.close_key_code;

		// keypad floor calls
		if (filt.key_hit && {1'b0, filt.key} < FC) begin
			if (known) begin
				if (mode_q == MODE_STOP && filt.key == fnow_q && !mid
						&& (filt.bottom || filt.flr)) begin
					fdoor = 1'b0;
					if (door_d == DOOR_CLOSED) begin
						door_d = DOOR_OPENING; dtmr_d = 16'd0;
					end
				end else calls_d[filt.key] = 1'b1;
			end else if (filt.key == 4'd0) homereq = 1'b1;
		end

		if (mode_q == MODE_UP) begin
			rtmr_d = rtmr_d + 16'd1;
			if (filt.rise) begin
				rtmr_d = 16'd0; passed = 1'b0;
				if (mid) begin
					mid = 1'b0;
					if ({1'b0, fnow_d} < TOP) fnow_d = fnow_d + 4'd1;
					else begin fcnt = 1'b1; known = 1'b0; end
					arr = 1'b1;
				end
			end
			if (filt.fall) begin rtmr_d = 16'd0; passed = 1'b0; mid = 1'b1; end
			if (filt.sup) begin
				rtmr_d = 16'd0;
				if (mid) begin
					if ({1'b0, fnow_d} + 5'd1 == {1'b0, goal_d}) fast = 1'b0;
					else passed = 1'b1;
				end
			end
			fu = find_up(calls_d, {1'b0, fnow_d} + 5'd1);
			if (!fcnt && fu.ok) begin
				f2 = fu;
				if ({1'b0, fu.hit} == {1'b0, fnow_d} + 5'd1 && passed && fu.hit != goal_d)
					f2 = find_up(calls_d, {1'b0, fnow_d} + 5'd2);
				if (f2.ok && f2.hit < goal_d) goal_d = f2.hit;
			end
			if (rtmr_d > cfg.run_timeout_ticks) ftime = 1'b1;
			reached = arr && !fcnt && fnow_d >= goal_d;
			if (reached || fcnt || sw_fault || ftime || filt.chain || filt.down_press) begin
				fast = 1'b0; mode_d = MODE_STOP; lock_d = cfg.stop_lock_ticks;
				if (reached) begin
					calls_d[fnow_d] = 1'b0; door_d = DOOR_OPENING; dtmr_d = 16'd0;
				end else calls_d = 16'd0;
			end
		end else if (mode_q == MODE_DOWN) begin
			rtmr_d = rtmr_d + 16'd1;
			if (!homing) begin
				if (filt.rise) begin
					rtmr_d = 16'd0; passed = 1'b0; mid = 1'b0; arr = 1'b1;
				end
				if (filt.fall) begin
					rtmr_d = 16'd0; passed = 1'b0;
					if (!mid) begin
						if (fnow_d != 4'd0) fnow_d = fnow_d - 4'd1;
						mid = 1'b1;
					end
				end
				if (filt.sdn) begin
					rtmr_d = 16'd0;
					if (mid) begin
						if (fnow_d == goal_d) fast = 1'b0;
						else passed = 1'b1;
					end
				end
				idx = mid ? {1'b0, fnow_d}
					: ((fnow_d != 4'd0) ? {1'b0, fnow_d} - 5'd1 : 5'd0);
				fd = find_down(calls_d, idx);
				if (fd.ok) begin
					f2 = fd;
					if ({1'b0, fd.hit} == idx && passed && fd.hit != goal_d)
						f2 = (idx != 5'd0) ? find_down(calls_d, idx - 5'd1) : '0;
					if (f2.ok && f2.hit > goal_d) goal_d = f2.hit;
				end
			end else if (filt.rise || filt.fall || filt.sup || filt.sdn) rtmr_d = 16'd0;
			if (filt.bottom) begin fnow_d = 4'd0; mid = 1'b0; known = 1'b1; end
			if (rtmr_d > cfg.run_timeout_ticks) ftime = 1'b1;
			reached = filt.bottom
				|| (!homing && arr && goal_d != 4'd0 && fnow_d <= goal_d);
			if (reached || sw_fault || fcnt || ftime || filt.chain || filt.up_press) begin
				fast = 1'b0; mode_d = MODE_STOP; homing = 1'b0;
				lock_d = cfg.stop_lock_ticks;
				if (reached) begin
					calls_d[fnow_d] = 1'b0; door_d = DOOR_OPENING; dtmr_d = 16'd0;
				end else calls_d = 16'd0;
			end
		end else begin
			mode_d = MODE_STOP;
			fast = 1'b0;
			// hall buttons
			if (filt.up_press && known && {1'b0, fnow_d} < TOP)
				calls_d[fnow_d + 4'd1] = 1'b1;
			if (filt.down_press) begin
				if (!known) homereq = 1'b1;
				else if (mid) calls_d[fnow_d] = 1'b1;
				else if (fnow_d != 4'd0) calls_d[fnow_d - 4'd1] = 1'b1;
			end
			// start a run once the stop lock has expired
			if (lock_d != 8'd0) lock_d = lock_d - 8'd1;
			else if (!sw_fault && !filt.chain) begin
				door_ok = door_d == DOOR_CLOSED && filt.dclosed;
				if (homereq && door_ok) begin
					homereq = 1'b0; calls_d = 16'd0; ftime = 1'b0; fcnt = 1'b0;
					homing = 1'b1; rtmr_d = 16'd0; mode_d = MODE_DOWN;
				end else if (calls_d != 16'd0 && door_ok && known) begin
					if (!mid && (filt.bottom || filt.flr) && calls_d[fnow_d]) begin
						calls_d[fnow_d] = 1'b0; door_d = DOOR_OPENING; dtmr_d = 16'd0;
					end else begin
						fu = ({1'b0, fnow_d} < TOP) ? find_up(calls_d, {1'b0, fnow_d} + 5'd1)
							: '0;
						fd = mid ? find_down(calls_d, {1'b0, fnow_d})
							: ((fnow_d != 4'd0) ? find_down(calls_d, {1'b0, fnow_d} - 5'd1)
							: '0);
						if (lastup) begin
							if (fu.ok) begin pick = fu.hit; go = 1'b1; go_up = 1'b1; end
							else if (fd.ok) begin pick = fd.hit; go = 1'b1; end
						end else begin
							if (fd.ok) begin pick = fd.hit; go = 1'b1; end
							else if (fu.ok) begin pick = fu.hit; go = 1'b1; go_up = 1'b1; end
						end
						if (go) begin
							goal_d = pick; lastup = go_up; passed = 1'b0; ftime = 1'b0;
							rtmr_d = 16'd0; fast = 1'b1;
							mode_d = go_up ? MODE_UP : MODE_DOWN;
						end
					end
				end
			end
		end

		// door state machine, held while the car runs
		if (mode_d == MODE_STOP) begin
			unique case (door_d)
				DOOR_OPENING: begin
					open_drv = 1'b1;
					dtmr_d = dtmr_d + 16'd1;
					if (close_key || filt.dopen || dtmr_d > cfg.door_move_ticks) begin
						open_drv = 1'b0;
						if (!filt.dopen && dtmr_d > cfg.door_move_ticks) fdoor = 1'b1;
						door_d = DOOR_OPEN; dtmr_d = 16'd0;
					end
				end
				DOOR_OPEN: begin
					dtmr_d = dtmr_d + 16'd1;
					if (open_key) dtmr_d = 16'd0;
					if (close_key || calls_d != 16'd0 || homereq
							|| dtmr_d > cfg.door_hold_ticks) begin
						door_d = DOOR_CLOSING; dtmr_d = 16'd0;
					end
				end
				DOOR_CLOSING: begin
					close_drv = 1'b1;
					dtmr_d = dtmr_d + 16'd1;
					if (open_key) begin
						close_drv = 1'b0; door_d = DOOR_OPENING; dtmr_d = 16'd0;
					end else if (filt.dclosed) begin
						close_drv = 1'b0; door_d = DOOR_CLOSED; dtmr_d = 16'd0;
						cfail_d = 4'd0;
					end else if (dtmr_d > cfg.door_move_ticks) begin
						close_drv = 1'b0; dtmr_d = 16'd0;
						cfail_d = cfail_d + 4'd1;
						if (cfail_d >= cfg.close_tries_max) begin
							fdoor = 1'b1; cfail_d = 4'd0;
						end
						door_d = DOOR_OPENING;
					end
				end
				default: begin
					if (open_key) begin
						fdoor = 1'b0; door_d = DOOR_OPENING; dtmr_d = 16'd0;
					end
				end
			endcase
		end

		// display code
		if (sw_fault) status = {ST_SWITCH, 4'd0};
		else if (fcnt) status = {ST_COUNT, 4'd0};
		else if (mode_d == MODE_UP) status = {ST_UP, goal_d};
		else if (mode_d == MODE_DOWN)
			status = homing ? {ST_HOMING, 4'd0} : {ST_DOWN, goal_d};
		else if (fdoor) status = {ST_DOORFLT, 4'd0};
		else if (door_d == DOOR_OPENING) status = {ST_OPENING, 4'd0};
		else if (door_d == DOOR_OPEN) status = {ST_OPEN, 4'd0};
		else if (door_d == DOOR_CLOSING) status = {ST_CLOSING, 4'd0};
		else if (filt.chain) status = {ST_CHAIN, 4'd0};
		else if (ftime) status = {ST_TIMEOUT, 4'd0};
		else if (!known) status = {ST_UNKNOWN, 4'd0};
		else if (filt.bottom || filt.flr) status = {ST_FLOOR, fnow_d};
		else status = {ST_BETWEEN, 4'd0};

		res.drive_up         = mode_d == MODE_UP;
		res.drive_down       = mode_d == MODE_DOWN;
		res.drive_fast       = fast;
		res.door_open_drive  = open_drv;
		res.door_close_drive = close_drv;
		res.car_floor        = fnow_d;
		res.goal_floor       = goal_d;
		res.call_mask        = calls_d;
		res.status_code      = status;
		res.fault_flags      = {fdoor, ftime, fcnt, sw_fault};
		res.arrived          = reached;
	end

	// commit state on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOP; door_q <= DOOR_CLOSED;
			fnow_q <= 4'd0; goal_q <= 4'd0; calls_q <= 16'd0;
			mid_q <= 1'b0; known_q <= 1'b0; homing_q <= 1'b0; homereq_q <= 1'b0;
			lastup_q <= 1'b0; passed_q <= 1'b0; fast_q <= 1'b0;
			dtmr_q <= 16'd0; rtmr_q <= 16'd0; cfail_q <= 4'd0; lock_q <= 8'd0;
			fcnt_q <= 1'b0; ftime_q <= 1'b0; fdoor_q <= 1'b0;
		end else if (en) begin
			mode_q <= mode_d; door_q <= door_d;
			fnow_q <= fnow_d; goal_q <= goal_d; calls_q <= calls_d;
			mid_q <= mid; known_q <= known; homing_q <= homing; homereq_q <= homereq;
			lastup_q <= lastup; passed_q <= passed; fast_q <= fast;
			dtmr_q <= dtmr_d; rtmr_q <= rtmr_d; cfail_q <= cfail_d; lock_q <= lock_d;
			fcnt_q <= fcnt; ftime_q <= ftime; fdoor_q <= fdoor;
		end
	end

endmodule
`default_nettype wire
